@@ design/vps_pkg.sv @@
`default_nettype none

package vps_pkg;

    localparam int FIFO_DEPTH    = 16;
    localparam int DURATION_BITS = 16;

    localparam int ACTION_W = 3;
    localparam int LEVEL_W  = 8;
    localparam int DUR_IN_W = 16;
    localparam int QSTEP_W  = 5;
    localparam int PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam longint unsigned DUR_MAX = (64'd1 << DURATION_BITS) - 64'd1;

    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [DURATION_BITS-1:0] dur_t;
    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_VIBRATE = 3'd0,
        ACT_SET     = 3'd1,
        ACT_TICK    = 3'd2,
        ACT_SUSPEND = 3'd3,
        ACT_RESUME  = 3'd4
    } action_t;

    typedef struct packed {
        level_t level;
        dur_t   duration;
    } step_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        level_t              level;
        logic [DUR_IN_W-1:0] duration_ms;
    } item_t;

    typedef struct packed {
        logic  clear;
        logic  push;
        logic  pop;
        step_t wr_step;
    } fifo_ctl_t;

    typedef struct packed {
        cnt_t  count;
        step_t head;
    } fifo_stat_t;

    typedef struct packed {
        logic               pin_out;
        level_t             current_level;
        logic [QSTEP_W-1:0] queued_steps;
        logic               timer_running;
        logic               dropped;
    } result_t;

    function automatic logic level_on(input level_t lvl);
        return (lvl != '0) && !lvl[LEVEL_W-1];
    endfunction

    function automatic dur_t sat_duration(input logic [DUR_IN_W-1:0] d);
        logic [64:0] dw;
        dw = 65'(d);
        if (dw > 65'(DUR_MAX)) begin
            return dur_t'(DUR_MAX);
        end
        return dur_t'(dw);
    endfunction

endpackage

`default_nettype wire

@@ design/vps_if.sv @@
`default_nettype none

interface vps_req_if;
    import vps_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    level_t              level;
    logic [DUR_IN_W-1:0] duration_ms;
    modport source(output valid, action, level, duration_ms, input ready);
    modport sink(input valid, action, level, duration_ms, output ready);
endinterface

interface vps_rsp_if;
    import vps_pkg::*;
    logic               valid;
    logic               ready;
    logic               pin_out;
    level_t             current_level;
    logic [QSTEP_W-1:0] queued_steps;
    logic               timer_running;
    logic               dropped;
    modport source(output valid, pin_out, current_level, queued_steps, timer_running, dropped,
                   input ready);
    modport sink(input valid, pin_out, current_level, queued_steps, timer_running, dropped,
                 output ready);
endinterface

interface vps_cfg_if;
    logic valid;
    logic ready;
    logic pin_invert;
    modport source(output valid, pin_invert, input ready);
    modport sink(input valid, pin_invert, output ready);
endinterface

`default_nettype wire

@@ design/vps_step_fifo.sv @@
`default_nettype none

module vps_step_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vps_pkg::fifo_ctl_t ctl,
    output vps_pkg::fifo_stat_t     stat
);
    import vps_pkg::*;

    step_t mem_reg [FIFO_DEPTH];
    ptr_t  head_reg;
    ptr_t  head_next;
    ptr_t  tail_reg;
    ptr_t  tail_next;
    cnt_t  count_reg;
    cnt_t  count_next;

    function automatic ptr_t ptr_inc(input ptr_t p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + ptr_t'(1);
    endfunction

    always_ff @(posedge clk) begin
        if (ctl.push && !ctl.clear) begin
            mem_reg[tail_reg] <= ctl.wr_step;
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (ctl.push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + cnt_t'(1);
        end else if (ctl.pop) begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.head  = mem_reg[head_reg];

endmodule

`default_nettype wire

@@ design/vps_ctrl.sv @@
`default_nettype none

module vps_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire vps_pkg::item_t      item,
    input  wire logic                cfg_we,
    input  wire logic                cfg_invert,
    input  wire vps_pkg::fifo_stat_t fstat,
    output vps_pkg::fifo_ctl_t       fctl,
    output vps_pkg::result_t         res
);
    import vps_pkg::*;

    dur_t   ticks_reg;
    dur_t   ticks_next;
    dur_t   ticks_dec;
    logic   armed_reg;
    logic   armed_next;
    level_t level_reg;
    level_t level_next;
    logic   pin_reg;
    logic   pin_next;
    logic   al_reg;
    logic   al_next;
    logic   apply_en;
    level_t apply_lvl;
    logic   dropped;
    cnt_t   cnt_next;

    assign ticks_dec = (ticks_reg == '0) ? '0 : ticks_reg - dur_t'(1);

    always_comb begin
        ticks_next   = ticks_reg;
        armed_next   = armed_reg;
        level_next   = level_reg;
        pin_next     = pin_reg;
        al_next      = al_reg;
        apply_en     = 1'b0;
        apply_lvl    = '0;
        dropped      = 1'b0;
        cnt_next     = fstat.count;
        fctl.clear   = 1'b0;
        fctl.push    = 1'b0;
        fctl.pop     = 1'b0;
        fctl.wr_step = '{level: item.level, duration: sat_duration(item.duration_ms)};

        if (cfg_we) begin
            al_next  = cfg_invert;
            pin_next = level_on(level_reg) ^ cfg_invert;
        end

        if (go) begin
            unique case (action_t'(item.action))
                ACT_VIBRATE: begin
                    if (item.level == '0 && item.duration_ms == '0) begin
                        armed_next = 1'b0;
                        ticks_next = '0;
                        fctl.clear = 1'b1;
                        cnt_next   = '0;
                        apply_en   = 1'b1;
                    end else if (fstat.count >= CNT_W'(FIFO_DEPTH)) begin
                        dropped = 1'b1;
                    end else begin
                        fctl.push = 1'b1;
                        cnt_next  = fstat.count + cnt_t'(1);
                        if (fstat.count == '0) begin
                            armed_next = 1'b1;
                            ticks_next = dur_t'(1);
                        end
                    end
                end
                ACT_SET: begin
                    apply_en  = 1'b1;
                    apply_lvl = item.level;
                end
                ACT_TICK: begin
                    if (armed_reg) begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == '0) begin
                            if (fstat.count == '0) begin
                                apply_en   = 1'b1;
                                armed_next = 1'b0;
                                ticks_next = '0;
                            end else begin
                                fctl.pop   = 1'b1;
                                cnt_next   = fstat.count - cnt_t'(1);
                                apply_en   = 1'b1;
                                apply_lvl  = fstat.head.level;
                                armed_next = 1'b1;
                                ticks_next = (fstat.head.duration == '0) ? dur_t'(1)
                                                                         : fstat.head.duration;
                            end
                        end
                    end
                end
                ACT_SUSPEND: begin
                    pin_next = al_reg;
                end
                ACT_RESUME: begin
                    pin_next = level_on(level_reg) ^ al_reg;
                end
                default: begin
                end
            endcase

            if (apply_en && apply_lvl != level_reg) begin
                level_next = apply_lvl;
                pin_next   = level_on(apply_lvl) ^ al_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ticks_reg <= '0;
            armed_reg <= 1'b0;
            level_reg <= '0;
            pin_reg   <= 1'b0;
            al_reg    <= 1'b0;
        end else begin
            ticks_reg <= ticks_next;
            armed_reg <= armed_next;
            level_reg <= level_next;
            pin_reg   <= pin_next;
            al_reg    <= al_next;
        end
    end

    assign res.pin_out       = pin_next;
    assign res.current_level = level_next;
    assign res.queued_steps  = QSTEP_W'(cnt_next);
    assign res.timer_running = armed_next;
    assign res.dropped       = dropped;

endmodule

`default_nettype wire

@@ design/vibration_pattern_sequencer.sv @@
// Vibration pattern sequencer. Each command or millisecond tick taken on req produces exactly
// one status transfer on rsp, in order. An item passes an input register and a result
// register, in that order, before its status is offered on rsp; a stall on rsp can hold the
// item in the input register. The block takes one item in every cycle as long as rsp is
// drained; the state update of one item is done by combinational logic in vps_ctrl. The step
// FIFO holds sixteen entries. The cfg port is always ready, and a write of pin_invert
// redrives the pin at once; write it only while no item is in flight.
`default_nettype none

module vibration_pattern_sequencer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vps_req_if.sink    req,
    vps_rsp_if.source  rsp,
    vps_cfg_if.sink    cfg
);
    import vps_pkg::*;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    logic       advance;
    logic       cfg_we;
    fifo_ctl_t  fctl;
    fifo_stat_t fstat;
    result_t    res;

    assign advance   = in_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (req.valid && req.ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
            end else if (rsp.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.valid && req.ready) begin
            item_reg <= '{action: req.action, level: req.level, duration_ms: req.duration_ms};
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    vps_step_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .stat  (fstat)
    );

    vps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (advance),
        .item       (item_reg),
        .cfg_we     (cfg_we),
        .cfg_invert (cfg.pin_invert),
        .fstat      (fstat),
        .fctl       (fctl),
        .res        (res)
    );

    assign rsp.valid         = res_valid_reg;
    assign rsp.pin_out       = res_reg.pin_out;
    assign rsp.current_level = res_reg.current_level;
    assign rsp.queued_steps  = res_reg.queued_steps;
    assign rsp.timer_running = res_reg.timer_running;
    assign rsp.dropped       = res_reg.dropped;

endmodule

`default_nettype wire

@@ test/vibration_pattern_sequencer_tb.sv @@
module vibration_pattern_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vps_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        item_t   cmd;
        bit      typed;
        result_t want;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n;

    vps_req_if req();
    vps_rsp_if rsp();
    vps_cfg_if cfg();

    vibration_pattern_sequencer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    level_t  step_level [FIFO_DEPTH];
    dur_t    step_dur [FIFO_DEPTH];
    int      q_head = 0;
    int      q_tail = 0;
    int      q_count = 0;
    int      ms_left = 0;
    bit      armed = 1'b0;
    level_t  held_level = '0;
    bit      pin_state = 1'b0;
    bit      polarity = 1'b0;

    result_t status_q [$];
    vector_t directed [$];
    result_t oldest;

    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int drop_count = 0;
    int polarity_writes = 0;
    int cycle_count = 0;
    int stall_left = 0;
    int burst_left = 0;
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    function automatic void set_pin_from(level_t lvl);
        pin_state = (lvl > 0) ^ polarity;
    endfunction

    function automatic void take_level(level_t lvl);
        if (held_level != lvl)
        begin
            set_pin_from(lvl);
            held_level = lvl;
        end
    endfunction

    function automatic result_t sequence_step(item_t c);
        result_t r;
        bit      drop;
        drop = 1'b0;
        case (c.action)
            ACT_VIBRATE:
            begin
                if (c.level == 0 && c.duration_ms == 0)
                begin
                    armed = 1'b0;
                    ms_left = 0;
                    q_head = 0;
                    q_tail = 0;
                    q_count = 0;
                    take_level('0);
                end
                else if (q_count >= FIFO_DEPTH)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    step_level[q_tail] = c.level;
                    step_dur[q_tail] = dur_t'(c.duration_ms);
                    q_tail = (q_tail + 1) % FIFO_DEPTH;
                    q_count++;
                    if (q_count == 1)
                    begin
                        armed = 1'b1;
                        ms_left = 1;
                    end
                end
            end
            ACT_SET:
            begin
                take_level(c.level);
            end
            ACT_TICK:
            begin
                if (armed)
                begin
                    if (ms_left > 0)
                    begin
                        ms_left--;
                    end
                    if (ms_left == 0)
                    begin
                        if (q_count == 0)
                        begin
                            take_level('0);
                            armed = 1'b0;
                        end
                        else
                        begin
                            take_level(step_level[q_head]);
                            ms_left = (step_dur[q_head] == 0) ? 1 : int'(step_dur[q_head]);
                            q_head = (q_head + 1) % FIFO_DEPTH;
                            q_count--;
                            armed = 1'b1;
                        end
                    end
                end
            end
            ACT_SUSPEND:
            begin
                set_pin_from('0);
            end
            ACT_RESUME:
            begin
                set_pin_from(held_level);
            end
            default:
            begin
            end
        endcase
        if (drop)
        begin
            drop_count++;
        end
        r.pin_out = pin_state;
        r.current_level = held_level;
        r.queued_steps = QSTEP_W'(q_count);
        r.timer_running = armed;
        r.dropped = drop;
        return r;
    endfunction

    function automatic void add_vector(logic [ACTION_W-1:0] act, int lvl, int dur, bit typed,
                                       bit pin, int cur, int queued, bit running, bit drop);
        vector_t v;
        v.cmd.action = act;
        v.cmd.level = level_t'(lvl);
        v.cmd.duration_ms = DUR_IN_W'(dur);
        v.typed = typed;
        v.want.pin_out = pin;
        v.want.current_level = level_t'(cur);
        v.want.queued_steps = QSTEP_W'(queued);
        v.want.timer_running = running;
        v.want.dropped = drop;
        directed.push_back(v);
    endfunction

    function automatic logic [DUR_IN_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return DUR_IN_W'($urandom_range(0, 3));
        end
        else if (r < 9)
        begin
            return DUR_IN_W'($urandom_range(0, 30));
        end
        return DUR_IN_W'($urandom);
    endfunction

    function automatic item_t pick_command();
        item_t c;
        int    r;
        c.level = level_t'($urandom);
        c.duration_ms = pick_duration();
        c.action = ACT_VIBRATE;
        if (burst_left > 0)
        begin
            burst_left--;
            return c;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(13, 20);
        end
        else if (r < 35)
        begin
            c.action = ACT_VIBRATE;
        end
        else if (r < 39)
        begin
            c.level = '0;
            c.duration_ms = '0;
        end
        else if (r < 47)
        begin
            c.action = ACT_SET;
            if ($urandom_range(0, 1) == 0)
            begin
                c.level = held_level;
            end
        end
        else if (r < 85)
        begin
            c.action = ACT_TICK;
        end
        else if (r < 91)
        begin
            c.action = ACT_SUSPEND;
        end
        else if (r < 97)
        begin
            c.action = ACT_RESUME;
        end
        else
        begin
            c.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s at status %0d: got %0d, expected %0d",
                 what, checked_count, got, want);
        fail_count++;
    endtask

    task automatic push_command(item_t c, bit typed, result_t want);
        result_t got;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= c.action;
        req.level <= c.level;
        req.duration_ms <= c.duration_ms;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        got = sequence_step(c);
        status_q.push_back(typed ? want : got);
        sent_count++;
    endtask

    task automatic wait_for_status();
        req.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (status_q.size() != 0);
    endtask

    task automatic set_polarity(bit v);
        cfg.valid <= 1'b1;
        cfg.pin_invert <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        polarity = v;
        set_pin_from(held_level);
        polarity_writes++;
    endtask

    always @(posedge clk)
    begin
        if (!idle_on || !rst_n)
        begin
            stall_left <= 0;
            rsp.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 17) - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (status_q.size() == 0)
            begin
                report_mismatch("unexpected status transfer", 1, 0);
            end
            else
            begin
                oldest = status_q.pop_front();
                checked_count++;
                if (rsp.pin_out !== oldest.pin_out)
                begin
                    report_mismatch("pin_out", rsp.pin_out, oldest.pin_out);
                end
                if (rsp.current_level !== oldest.current_level)
                begin
                    report_mismatch("current_level", rsp.current_level, oldest.current_level);
                end
                if (rsp.queued_steps !== oldest.queued_steps)
                begin
                    report_mismatch("queued_steps", rsp.queued_steps, oldest.queued_steps);
                end
                if (rsp.timer_running !== oldest.timer_running)
                begin
                    report_mismatch("timer_running", rsp.timer_running, oldest.timer_running);
                end
                if (rsp.dropped !== oldest.dropped)
                begin
                    report_mismatch("dropped", rsp.dropped, oldest.dropped);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.action <= ACT_TICK;
        req.level <= '0;
        req.duration_ms <= '0;
        cfg.valid <= 1'b0;
        cfg.pin_invert <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_vector(ACT_TICK, 0, 0, 1, 0, 0, 0, 0, 0);
        add_vector(ACT_SET, 127, 0, 1, 1, 127, 0, 0, 0);
        add_vector(ACT_SET, 127, 16'hFFFF, 1, 1, 127, 0, 0, 0);
        add_vector(ACT_SET, -128, 0, 1, 0, -128, 0, 0, 0);
        add_vector(ACT_SUSPEND, 0, 0, 1, 0, -128, 0, 0, 0);
        add_vector(ACT_SET, 1, 0, 1, 1, 1, 0, 0, 0);
        add_vector(ACT_SUSPEND, 0, 0, 1, 0, 1, 0, 0, 0);
        add_vector(ACT_RESUME, 0, 0, 1, 1, 1, 0, 0, 0);
        add_vector(ACT_VIBRATE, 0, 0, 1, 0, 0, 0, 0, 0);
        add_vector(ACT_VIBRATE, 127, 16'hFFFF, 1, 0, 0, 1, 1, 0);
        add_vector(ACT_VIBRATE, -128, 0, 1, 0, 0, 2, 1, 0);
        add_vector(ACT_TICK, 0, 0, 1, 1, 127, 1, 1, 0);
        add_vector(ACT_TICK, 0, 0, 1, 1, 127, 1, 1, 0);
        add_vector(ACT_VIBRATE, 5, 3, 1, 1, 127, 2, 1, 0);
        add_vector(ACT_VIBRATE, 0, 0, 1, 0, 0, 0, 0, 0);
        add_vector(ACT_VIBRATE, 0, 2, 1, 0, 0, 1, 1, 0);
        add_vector(ACT_TICK, 0, 0, 1, 0, 0, 0, 1, 0);
        add_vector(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_vector(ACT_VIBRATE, 9, 1, 0, 0, 0, 0, 0, 0);
        add_vector(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_vector(ACT_SPARE_FIRST, -1, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        add_vector(ACT_SPARE_FIRST + 3'd1, 8'h55, 16'hAAAA, 0, 0, 0, 0, 0, 0);
        add_vector(ACT_SPARE_LAST, 8'hAA, 16'h5555, 0, 0, 0, 0, 0, 0);
        add_vector(ACT_TICK, 0, 0, 1, 0, 0, 0, 0, 0);
        add_vector(ACT_SET, -1, 0, 1, 0, -1, 0, 0, 0);

        foreach (directed[i])
        begin
            push_command(directed[i].cmd, directed[i].typed, directed[i].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_status();
            set_polarity(phase % 2 == 0);
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (n % 50 == 0)
                begin
                    idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                if (phase == 1 && n == 150)
                begin
                    wait_for_status();
                end
                push_command(pick_command(), 1'b0, '0);
            end
        end

        wait_for_status();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (status_q.size() != 0)
        begin
            report_mismatch("statuses never delivered", 0, status_q.size());
        end
        $display("Sent %0d commands and ticks and checked %0d status transfers.",
                 sent_count, checked_count);
        $display("The queue overflowed %0d times, and the pin polarity was written %0d times.",
                 drop_count, polarity_writes);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/vps_pkg.sv
design/vps_if.sv
design/vps_step_fifo.sv
design/vps_ctrl.sv
design/vibration_pattern_sequencer.sv
test/vibration_pattern_sequencer_tb.sv
